FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the dirty message cache core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DMC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types, widths and codes of the dirty message cache.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  // Cache geometry
  localparam int SLOTS  = 5;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HEAD_W = 64;
  localparam int TAIL_W = 24;
  localparam int KEY_W  = HEAD_W + TAIL_W;
  localparam int VAL_W  = 32;
  localparam int NAME_BYTES = KEY_W / 8;

  // Input opcodes
  localparam logic [1:0] OP_SET     = 2'd0;
  localparam logic [1:0] OP_STOPPED = 2'd1;
  localparam logic [1:0] OP_TIMER   = 2'd2;

  // Result actions
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SEND = 2'd1,
    ACT_STOP = 2'd2,
    ACT_IDLE = 2'd3
  } action_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PICK
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic commit_set;  // apply a set item to the stores
    logic load_out;    // fill the result register
    logic pick;        // result comes from the dirty slot scan
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;    // result register can take a new item
    logic is_set;      // held item is a set
    logic is_stopped;  // held item reports a finished transmission
    logic need_pick;   // set item dirties a slot while the broadcaster idles
  } status_t;

endpackage

`default_nettype wire

FILE: design/dmc_ctrl.sv
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer of the dirty message cache: accept, execute, optional scan.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire dmc_pkg::status_t status,
  output dmc_pkg::cmd_t         cmd
);

  dmc_pkg::state_t state_r, state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dmc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = dmc_pkg::S_EXEC;
      end
      dmc_pkg::S_EXEC: begin
        if (status.out_free) begin
          state_nxt = status.need_pick ? dmc_pkg::S_PICK : dmc_pkg::S_IDLE;
        end
      end
      dmc_pkg::S_PICK: begin
        if (status.out_free) state_nxt = dmc_pkg::S_IDLE;
      end
      default: state_nxt = dmc_pkg::S_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      dmc_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      dmc_pkg::S_EXEC: begin
        if (status.out_free) begin
          cmd.commit_set = status.is_set;
          cmd.load_out   = !status.need_pick;
          cmd.pick       = status.is_stopped;
        end
      end
      dmc_pkg::S_PICK: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.pick     = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/dmc_datapath.sv
// ----------------------------------------------------------------------------
// dmc_datapath
// Slot stores, name match, dirty scan and result register of the cache.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire dmc_pkg::cmd_t                      cmd,
  output dmc_pkg::status_t                        status,
  input  wire logic [1:0]                         in_opcode,
  input  wire logic [dmc_pkg::HEAD_W-1:0]         in_key_head,
  input  wire logic [dmc_pkg::TAIL_W-1:0]         in_key_tail,
  input  wire logic signed [dmc_pkg::VAL_W-1:0]   in_new_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [1:0]                              out_action,
  output logic [2:0]                              out_slot,
  output logic [dmc_pkg::HEAD_W-1:0]              out_key_head,
  output logic [dmc_pkg::TAIL_W-1:0]              out_key_tail,
  output logic signed [dmc_pkg::VAL_W-1:0]        out_value
);

  localparam int           N    = dmc_pkg::SLOTS;
  localparam int           IW   = dmc_pkg::IDX_W;
  localparam logic [IW-1:0] LAST = IW'(N - 1);

  // Zero every name byte after the first zero byte
  function automatic logic [dmc_pkg::KEY_W-1:0] terminate(
    input logic [dmc_pkg::KEY_W-1:0] k
  );
    logic [dmc_pkg::KEY_W-1:0] r;
    logic                      ended;
    r     = k;
    ended = 1'b0;
    for (int b = 0; b < dmc_pkg::NAME_BYTES; b++) begin
      if (ended) r[b*8 +: 8] = 8'd0;
      else if (k[b*8 +: 8] == 8'd0) ended = 1'b1;
    end
    return r;
  endfunction

  // Held item
  logic [1:0]                       op_r;
  logic [dmc_pkg::KEY_W-1:0]        key_r;
  logic signed [dmc_pkg::VAL_W-1:0] val_r;

  // Slot stores
  logic [dmc_pkg::KEY_W-1:0]        slot_key_r [N];
  logic signed [dmc_pkg::VAL_W-1:0] slot_val_r [N];
  logic [N-1:0]                     mark_r;
  logic [IW-1:0]                    ptr_r;
  logic                             busy_r;
  logic                             out_valid_r;

  // Result register
  dmc_pkg::action_t                 out_action_r, out_action_nxt;
  logic [2:0]                       out_slot_r, out_slot_nxt;
  logic [dmc_pkg::HEAD_W-1:0]       out_head_r, out_head_nxt;
  logic [dmc_pkg::TAIL_W-1:0]       out_tail_r, out_tail_nxt;
  logic signed [dmc_pkg::VAL_W-1:0] out_value_r, out_value_nxt;

  // Match and scan results
  logic [N-1:0]  hit_vec, veq_vec;
  logic          hit_found, pick_found;
  logic [IW-1:0] hit_idx, pick_idx, wr_idx;
  logic          val_same, dirtied;

  // Latch the accepted item, name already terminated
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      key_r <= terminate({in_key_tail, in_key_head});
      val_r <= in_new_value;
    end
  end

  // Compare the held name and value against every slot
  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit_vec[i] = (slot_key_r[i] == key_r);
      veq_vec[i] = (slot_val_r[i] == val_r);
    end
  end

  // Lowest-index match
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_found = 1'b1;
        hit_idx   = IW'(i);
      end
    end
  end

  // Lowest-index dirty slot
  always_comb begin
    pick_found = 1'b0;
    pick_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (mark_r[i]) begin
        pick_found = 1'b1;
        pick_idx   = IW'(i);
      end
    end
  end

  assign val_same = hit_found && veq_vec[hit_idx];
  assign wr_idx   = hit_found ? hit_idx : ptr_r;
  assign dirtied  = !hit_found || (!val_same && !mark_r[hit_idx]);

  // Status back to the controller
  assign status.out_free   = !out_valid_r || out_ready;
  assign status.is_set     = (op_r == dmc_pkg::OP_SET);
  assign status.is_stopped = (op_r == dmc_pkg::OP_STOPPED);
  assign status.need_pick  = (op_r == dmc_pkg::OP_SET) && dirtied && !busy_r;

  // Update stores: apply a set, clear the mark of an emitted slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        slot_key_r[i] <= '0;
        slot_val_r[i] <= '0;
      end
      mark_r <= '0;
      ptr_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      if (cmd.commit_set && !val_same) begin
        slot_val_r[wr_idx] <= val_r;
        mark_r[wr_idx]     <= 1'b1;
        if (!hit_found) begin
          slot_key_r[wr_idx] <= key_r;
          ptr_r              <= (ptr_r == LAST) ? '0 : ptr_r + 1'b1;
        end
      end
      if (cmd.load_out && cmd.pick) begin
        busy_r <= pick_found;
        if (pick_found) mark_r[pick_idx] <= 1'b0;
      end
    end
  end

  // Hold result valid until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Select the result fields
  always_comb begin
    out_action_nxt = dmc_pkg::ACT_NONE;
    out_slot_nxt   = '0;
    out_head_nxt   = '0;
    out_tail_nxt   = '0;
    out_value_nxt  = '0;
    if (cmd.pick) begin
      if (pick_found) begin
        out_action_nxt = dmc_pkg::ACT_SEND;
        out_slot_nxt   = 3'(pick_idx);
        out_head_nxt   = slot_key_r[pick_idx][dmc_pkg::HEAD_W-1:0];
        out_tail_nxt   = slot_key_r[pick_idx][dmc_pkg::KEY_W-1:dmc_pkg::HEAD_W];
        out_value_nxt  = slot_val_r[pick_idx];
      end else begin
        out_action_nxt = dmc_pkg::ACT_IDLE;
      end
    end else if (op_r == dmc_pkg::OP_TIMER && busy_r) begin
      out_action_nxt = dmc_pkg::ACT_STOP;
    end
  end

  // Fill the result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_action_r <= out_action_nxt;
      out_slot_r   <= out_slot_nxt;
      out_head_r   <= out_head_nxt;
      out_tail_r   <= out_tail_nxt;
      out_value_r  <= out_value_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_action   = out_action_r;
  assign out_slot     = out_slot_r;
  assign out_key_head = out_head_r;
  assign out_key_tail = out_tail_r;
  assign out_value    = out_value_r;

endmodule

`default_nettype wire

FILE: design/dirty_message_cache_core.sv
// ----------------------------------------------------------------------------
// dirty_message_cache_core
// Keyed cache of named variables with dirty marks feeding a broadcaster.
// ----------------------------------------------------------------------------
// One item is in work at a time and every item yields exactly one result.
// An item is captured at acceptance, then matched and updated over all slots
// before its result is loaded; a set item that dirties a slot while the
// broadcaster is idle adds the lowest-index dirty scan, which runs on the
// marks after the update. The next item can be accepted in the cycle after
// the result is loaded, while that result may still wait in the output
// register. The slot stores clear at reset; no clearing pass is run.
`default_nettype none

`include "assert_macros.svh"

module dirty_message_cache_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_opcode,
  input  wire logic [dmc_pkg::HEAD_W-1:0]         in_key_head,
  input  wire logic [dmc_pkg::TAIL_W-1:0]         in_key_tail,
  input  wire logic signed [dmc_pkg::VAL_W-1:0]   in_new_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [1:0]                              out_action,
  output logic [2:0]                              out_slot,
  output logic [dmc_pkg::HEAD_W-1:0]              out_key_head,
  output logic [dmc_pkg::TAIL_W-1:0]              out_key_tail,
  output logic signed [dmc_pkg::VAL_W-1:0]        out_value
);

  dmc_pkg::cmd_t    cmd;
  dmc_pkg::status_t status;

  // Sequencer
  dmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Stores and result register
  dmc_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_opcode    (in_opcode),
    .in_key_head  (in_key_head),
    .in_key_tail  (in_key_tail),
    .in_new_value (in_new_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_action   (out_action),
    .out_slot     (out_slot),
    .out_key_head (out_key_head),
    .out_key_tail (out_key_tail),
    .out_value    (out_value)
  );

  // A result is never loaded over one that has not been taken
  `DMC_ASSERT(a_no_overwrite, cmd.load_out |-> status.out_free, "result overwritten")
  // Only one item is in work at a time
  `DMC_ASSERT(a_single_item, (in_valid && in_ready) |=> !in_ready, "second item accepted")
  // A loaded result is offered on the next cycle
  `DMC_ASSERT(a_load_shows, cmd.load_out |=> out_valid, "loaded result not offered")
  // Capture and commit never happen in the same cycle
  `DMC_ASSERT(a_capture_alone, cmd.capture |-> !(cmd.commit_set || cmd.load_out), "capture overlaps")

endmodule

`default_nettype wire

FILE: tb/tb_dirty_message_cache_core.sv
// ----------------------------------------------------------------------------
// tb_dirty_message_cache_core
// Self-checking bench for the dirty message cache core: a queue of set,
// stopped and timer items is driven over valid/ready, an in-bench cache
// model predicts each reply at acceptance, and the monitor compares every
// reply field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_dirty_message_cache_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dmc_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 1725;
  localparam int         POOL_SIZE    = 8;
  localparam int         STALL_LIMIT  = 4000;
  localparam int         HOLD_CYCLES  = 200;
  localparam int         DRAIN_CYCLES = 10;

  typedef struct {
    logic [1:0]        op;
    logic [HEAD_W-1:0] head;
    logic [TAIL_W-1:0] tail;
    logic [VAL_W-1:0]  value;
  } cache_req;

  typedef struct {
    action_t           action;
    logic [2:0]        slot;
    logic [HEAD_W-1:0] head;
    logic [TAIL_W-1:0] tail;
    logic [VAL_W-1:0]  value;
  } cache_reply;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [HEAD_W-1:0] in_key_head = '0;
  logic [TAIL_W-1:0] in_key_tail = '0;
  logic signed [VAL_W-1:0] in_new_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_action;
  logic [2:0] out_slot;
  logic [HEAD_W-1:0] out_key_head;
  logic [TAIL_W-1:0] out_key_tail;
  logic signed [VAL_W-1:0] out_value;

  cache_req   pending_reqs[$];
  cache_reply expected_replies[$];
  int total_items = 0;
  int issued_items = 0;
  int accepted_items = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  // Shadow copy of the cache and broadcaster
  logic [KEY_W-1:0] shadow_key [SLOTS];
  logic [VAL_W-1:0] shadow_val [SLOTS];
  logic             shadow_dirty [SLOTS];
  int               shadow_ptr = 0;
  logic             shadow_busy = 1'b0;

  dirty_message_cache_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_key_head  (in_key_head),
    .in_key_tail  (in_key_tail),
    .in_new_value (in_new_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_action   (out_action),
    .out_slot     (out_slot),
    .out_key_head (out_key_head),
    .out_key_tail (out_key_tail),
    .out_value    (out_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Drop every byte after the first zero byte of the name
  function automatic logic [KEY_W-1:0] trim_name(logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    logic ended;
    k = raw;
    ended = 1'b0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (ended) k[8*b +: 8] = 8'h00;
      else if (k[8*b +: 8] == 8'h00) ended = 1'b1;
    end
    return k;
  endfunction

  // Clear and emit the lowest dirty slot, or go idle
  function automatic cache_reply send_next_dirty();
    cache_reply r;
    r.action = ACT_IDLE;
    r.slot = '0;
    r.head = '0;
    r.tail = '0;
    r.value = '0;
    shadow_busy = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      if (shadow_dirty[s]) begin
        shadow_dirty[s] = 1'b0;
        shadow_busy = 1'b1;
        r.action = ACT_SEND;
        r.slot = 3'(s);
        r.head = shadow_key[s][HEAD_W-1:0];
        r.tail = shadow_key[s][KEY_W-1:HEAD_W];
        r.value = shadow_val[s];
        return r;
      end
    end
    return r;
  endfunction

  function automatic cache_reply predict_reply(logic [1:0] op, logic [HEAD_W-1:0] head,
                                               logic [TAIL_W-1:0] tail,
                                               logic [VAL_W-1:0] val);
    cache_reply r;
    logic [KEY_W-1:0] key;
    int hit;
    logic dirtied;
    r.action = ACT_NONE;
    r.slot = '0;
    r.head = '0;
    r.tail = '0;
    r.value = '0;
    hit = -1;
    dirtied = 1'b0;
    case (op)
      OP_STOPPED: r = send_next_dirty();
      OP_TIMER: if (shadow_busy) r.action = ACT_STOP;
      OP_SET: begin
        key = trim_name({tail, head});
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && shadow_key[i] == key) hit = i;
        end
        if (hit >= 0) begin
          if (shadow_val[hit] != val) begin
            shadow_val[hit] = val;
            if (!shadow_dirty[hit]) begin
              shadow_dirty[hit] = 1'b1;
              dirtied = 1'b1;
            end
          end
        end else begin
          shadow_key[shadow_ptr] = key;
          shadow_val[shadow_ptr] = val;
          shadow_dirty[shadow_ptr] = 1'b1;
          shadow_ptr = (shadow_ptr + 1) % SLOTS;
          dirtied = 1'b1;
        end
        if (dirtied && !shadow_busy) r = send_next_dirty();
      end
      default: ;
    endcase
    return r;
  endfunction

  // Stall mix: first sender light / receiver heavy, then swapped, then none
  function automatic int idle_phase();
    if (accepted_items < total_items / 3) return 0;
    if (accepted_items < 2 * total_items / 3) return 1;
    return 2;
  endfunction

  function automatic int sender_idle_pct();
    case (idle_phase())
      0: return 34;
      1: return 56;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (idle_phase())
      0: return 56;
      1: return 34;
      default: return 0;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] fresh_name(int len);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // Small values make equal-value hits common
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5, 6: return 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(logic [1:0] op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    cache_req r;
    r.op = op;
    r.head = key[HEAD_W-1:0];
    r.tail = key[KEY_W-1:HEAD_W];
    r.value = val;
    pending_reqs.push_back(r);
  endtask

  task automatic check_field(string field, logic [HEAD_W-1:0] want, logic [HEAD_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endtask

  // Build stimulus, reset, then wait for the last reply to drain
  initial begin : run_test
    logic [KEY_W-1:0] pool [POOL_SIZE];
    int pool_len [POOL_SIZE];
    logic [KEY_W-1:0] key;
    int roll;
    int pick;

    for (int s = 0; s < SLOTS; s++) begin
      shadow_key[s] = '0;
      shadow_val[s] = '0;
      shadow_dirty[s] = 1'b0;
    end

    // Directed: idle-side corner cases
    push_item(OP_TIMER, '0, '0);
    push_item(OP_STOPPED, '0, '0);
    push_item(OP_UNUSED, '1, '1);
    // empty name hits an unwritten slot with equal value, then a changed one
    push_item(OP_SET, '0, '0);
    push_item(OP_SET, {{TAIL_W{1'b1}}, {(HEAD_W-8){1'b1}}, 8'h00}, 32'd5);
    // miss while busy, timer while busy, equal hit, hit on a dirty slot
    push_item(OP_SET, KEY_W'(8'h41), 32'h7FFF_FFFF);
    push_item(OP_TIMER, '0, '0);
    push_item(OP_SET, KEY_W'(8'h41), 32'h7FFF_FFFF);
    push_item(OP_SET, {{TAIL_W{1'b1}}, 48'hFFFF_FFFF_FFFF, 16'h0041}, 32'h8000_0000);
    // full-length names and a terminator in the tail bytes
    push_item(OP_SET, '1, 32'hFFFF_FFFF);
    push_item(OP_SET, {{TAIL_W{1'b0}}, {HEAD_W{1'b1}}}, '0);
    push_item(OP_SET, {24'h00FF41, {8{8'h41}}}, 32'h0000_0001);
    // drain all dirty slots, then stop while idle
    for (int n = 0; n < 6; n++) push_item(OP_STOPPED, '0, '0);
    // wrap the insert pointer
    for (int n = 1; n <= SLOTS + 1; n++) push_item(OP_SET, fresh_name(n), 32'(n));
    push_item(OP_STOPPED, '0, '0);

    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_len[p] = $urandom_range(0, NAME_BYTES);
      pool[p] = fresh_name(pool_len[p]);
    end

    // Random: mostly sets on a small name pool, with stops and timers
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 149) begin
        pick = $urandom_range(POOL_SIZE - 1);
        pool_len[pick] = $urandom_range(0, NAME_BYTES);
        pool[pick] = fresh_name(pool_len[pick]);
      end
      roll = $urandom_range(99);
      if (roll < 70) begin
        pick = $urandom_range(POOL_SIZE - 1);
        key = pool[pick];
        // junk after the terminator must not change the name
        if ($urandom_range(3) == 0) begin
          for (int b = pool_len[pick] + 1; b < NAME_BYTES; b++)
            key[8*b +: 8] = 8'($urandom_range(0, 255));
        end
        push_item(OP_SET, key, pick_value());
      end else if (roll < 75) begin
        push_item(OP_SET, {24'($urandom), $urandom, $urandom}, $urandom);
      end else if (roll < 89) begin
        push_item(OP_STOPPED, {24'($urandom), $urandom, $urandom}, $urandom);
      end else if (roll < 97) begin
        push_item(OP_TIMER, {24'($urandom), $urandom, $urandom}, $urandom);
      end else begin
        push_item(OP_UNUSED, {24'($urandom), $urandom, $urandom}, $urandom);
      end
    end
    total_items = pending_reqs.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || accepted_items != issued_items) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Offer the next item once the current one is taken
  always @(negedge clk) begin : drive_items
    cache_req nxt;
    if (rst_n && (!in_valid || accepted_items == issued_items)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
        nxt = pending_reqs.pop_front();
        in_opcode <= nxt.op;
        in_key_head <= nxt.head;
        in_key_tail <= nxt.tail;
        in_new_value <= nxt.value;
        in_valid <= 1'b1;
        issued_items++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Random output stalls, plus one long hold-off to back up the input
  always @(negedge clk) begin : drive_ready
    if (!hold_done && total_items != 0 && accepted_items >= 2 * total_items / 3 + 40) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // Check replies, predict on acceptance, and watch for a hang
  always @(posedge clk) begin : watch_ports
    cache_reply want;
    if (rst_n) begin
      idle_cycles++;
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (expected_replies.size() == 0) begin
          $error("reply with no item waiting: action %0d slot %0d", out_action, out_slot);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          check_field("action", HEAD_W'(want.action), HEAD_W'(out_action));
          check_field("slot", HEAD_W'(want.slot), HEAD_W'(out_slot));
          check_field("out_key_head", want.head, out_key_head);
          check_field("out_key_tail", HEAD_W'(want.tail), HEAD_W'(out_key_tail));
          check_field("out_value", HEAD_W'(want.value), HEAD_W'($unsigned(out_value)));
        end
      end
      if (in_valid && in_ready) begin
        idle_cycles = 0;
        expected_replies.push_back(predict_reply(in_opcode, in_key_head, in_key_tail,
                                                 in_new_value));
        accepted_items++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
